// ===== src/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg
// Types, constants and helpers shared by the escape string decoder modules.
// ----------------------------------------------------------------------------
package ted_pkg;

    localparam logic [15:0] MAX_OUTPUT_BYTES = 16'd65535;
    localparam logic [15:0] LIMIT_RESET      = 16'd255;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TO_HIGH = 1'd1;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_CARET     = 8'h5e;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_QMARK     = 8'h3f;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_ESCAPE    = 8'h1b;
    localparam logic [7:0] CH_DELETE    = 8'h7f;
    localparam logic [7:0] CTRL_MASK    = 8'h1f;
    localparam logic [7:0] ZERO_SUBST   = 8'h80;

    typedef enum logic [2:0] {
        PH_START,
        PH_IDLE,
        PH_CARET,
        PH_ESC,
        PH_HEX0,
        PH_HEX1,
        PH_OCT,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        is_last;
        logic [15:0] total_length;
    } result_t;

    // Results produced by one decoded input item, entries [0 .. n-1] valid.
    typedef struct packed {
        logic [1:0]       n;
        result_t [2:0]    entries;
    } push_t;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters a-f / A-F have 1..6 in the low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39)
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== src/terminal_escape_string_decoder_top.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_string_decoder_top
// Capability string escape decoder with stream ports and a register port.
// ----------------------------------------------------------------------------
// Source bytes enter on the slave stream, one per request, with tlast marking
// the end of a string. A byte is registered, then decoded and its results
// (zero to three) are queued. Input is taken at one byte per cycle while each
// byte yields at most one result and m_tready is high; the single-result output
// port of the four-entry queue sets the pace, so a byte that yields two or three
// results holds input until the queue level falls to one or less. Registers:
// index 0 output limit (reset 255), index 1 zero-to-0x80 mode (reset 0); write
// them only between strings or while no request is in flight.
module terminal_escape_string_decoder_top
    import ted_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    input  logic                 s_tlast,   // is_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [7:0] out_byte, [23:8] total_length
    output logic                 m_tuser,   // has_byte
    output logic                 m_tlast,   // is_last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        in_move;
    logic [15:0] output_limit_reg;
    logic        zero_to_high_reg;
    logic [2:0]  fifo_level;
    push_t       push;
    result_t     head;

    // Room for the worst case of three results, judged on the registered level.
    assign in_move   = in_valid_reg && (fifo_level <= 3'd1);
    assign s_tready  = !in_valid_reg || in_move;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            output_limit_reg <= LIMIT_RESET;
            zero_to_high_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data;
                    CFG_ZERO_TO_HIGH: zero_to_high_reg <= cfg_data[0];
                    default:          output_limit_reg <= output_limit_reg;
                endcase
            end
        end
    end

    ted_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_move),
        .item_byte    (in_byte_reg),
        .item_end     (in_end_reg),
        .output_limit (output_limit_reg),
        .zero_to_high (zero_to_high_reg),
        .push         (push)
    );

    ted_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .level    (fifo_level),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {head.total_length, head.out_byte};
    assign m_tuser = head.has_byte;
    assign m_tlast = head.is_last;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= 3'd4)
        else $error("result queue level out of range");

    a_end_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_move && in_end_reg |=> m_tvalid)
        else $error("end of string produced no result");

    a_last_has_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tuser && (m_tdata[7:0] == 8'h00))
        else $error("final result carries a byte");

    a_byte_has_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata[23:8] == 16'd0))
        else $error("byte result carries a length");

endmodule

// ===== src/ted_result_fifo.sv =====
// ----------------------------------------------------------------------------
// ted_result_fifo
// Four-entry result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ted_result_fifo
    import ted_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic [2:0]  level,
    output logic        m_tvalid,
    input  logic        m_tready,
    output result_t     head
);

    result_t     mem_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  level_reg, level_next;
    logic        pop;

    assign pop      = (level_reg != 3'd0) && m_tready;
    assign m_tvalid = (level_reg != 3'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign level    = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        level_next  = level_reg + {1'b0, push.n} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push.n)
            begin
                mem_reg[wr_ptr_reg + 2'(i)] <= push.entries[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            level_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== src/ted_decode.sv =====
// ----------------------------------------------------------------------------
// ted_decode
// Decode state and the per-byte decode logic; yields up to three results.
// ----------------------------------------------------------------------------
module ted_decode
    import ted_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic [7:0]  item_byte,
    input  logic        item_end,
    input  logic [15:0] output_limit,
    input  logic        zero_to_high,
    output push_t       push
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  hex_digit_reg, hex_digit_next;
    logic        x_upper_reg, x_upper_next;
    logic [7:0]  octal_reg, octal_next;
    logic [15:0] count_reg, count_next;

    logic        stop_c;
    logic        plain_emit;
    phase_t      plain_phase;
    phase_t      cand_phase;
    logic [1:0]  np;
    logic [7:0]  pre0, pre1;
    logic        use_plain;
    logic [7:0]  x_char;
    logic [7:0]  cand [3];
    logic [1:0]  cand_n;
    logic [15:0] lim, room;
    logic [1:0]  n_ok;
    logic        reached;
    logic [7:0]  ob;

    assign stop_c = (item_byte == 8'h00) || (item_byte == CH_QUOTE);
    assign x_char = x_upper_reg ? CH_UPPER_X : CH_LOWER_X;

    // Ordinary character handling, used from the idle phase and by every phase that falls back to a plain byte.
    always_comb
    begin
        plain_emit = 1'b0;
        if (stop_c)
        begin
            plain_phase = PH_DONE;
        end
        else if (item_byte == CH_CARET)
        begin
            plain_phase = PH_CARET;
        end
        else if (item_byte == CH_BACKSLASH)
        begin
            plain_phase = PH_ESC;
        end
        else
        begin
            plain_phase = PH_IDLE;
            plain_emit  = 1'b1;
        end
    end

    always_comb
    begin
        np             = 2'd0;
        pre0           = 8'h00;
        pre1           = 8'h00;
        use_plain      = 1'b0;
        cand_phase     = phase_reg;
        hex_digit_next = hex_digit_reg;
        x_upper_next   = x_upper_reg;
        octal_next     = octal_reg;

        if (item_end)
        begin
            // flush a pending escape
            unique case (phase_reg)
                PH_CARET:
                begin
                    np = 2'd1; pre0 = CH_CARET;
                end
                PH_ESC:
                begin
                    np = 2'd1; pre0 = CH_BACKSLASH;
                end
                PH_HEX0:
                begin
                    np = 2'd1; pre0 = x_char;
                end
                PH_HEX1:
                begin
                    np = 2'd2; pre0 = x_char; pre1 = hex_digit_reg;
                end
                PH_OCT:
                begin
                    np = 2'd1; pre0 = octal_reg;
                end
                default:
                begin
                    np = 2'd0;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (item_byte == CH_QUOTE)
                    begin
                        cand_phase = PH_IDLE;
                    end
                    else
                    begin
                        use_plain = 1'b1;
                    end
                end
                PH_IDLE:
                begin
                    use_plain = 1'b1;
                end
                PH_CARET:
                begin
                    cand_phase = PH_IDLE;
                    np         = 2'd1;
                    if (stop_c)
                    begin
                        pre0      = CH_CARET;
                        use_plain = 1'b1;
                    end
                    else if (item_byte == CH_QMARK)
                    begin
                        pre0 = CH_DELETE;
                    end
                    else if (item_byte == CH_CARET)
                    begin
                        pre0 = CH_CARET;
                    end
                    else
                    begin
                        pre0 = item_byte & CTRL_MASK;
                    end
                end
                PH_ESC:
                begin
                    cand_phase = PH_IDLE;
                    np         = 2'd1;
                    if (stop_c)
                    begin
                        pre0      = CH_BACKSLASH;
                        use_plain = 1'b1;
                    end
                    else
                    begin
                        unique case (item_byte)
                            8'h65, 8'h45: pre0 = CH_ESCAPE;   // e E
                            8'h6e:        pre0 = 8'h0a;       // n
                            8'h72:        pre0 = 8'h0d;       // r
                            8'h74:        pre0 = 8'h09;       // t
                            8'h62:        pre0 = 8'h08;       // b
                            8'h66:        pre0 = 8'h0c;       // f
                            8'h73:        pre0 = 8'h20;       // s
                            CH_LOWER_X, CH_UPPER_X:
                            begin
                                np           = 2'd0;
                                x_upper_next = (item_byte == CH_UPPER_X);
                                cand_phase   = PH_HEX0;
                            end
                            default:
                            begin
                                if (is_oct(item_byte))
                                begin
                                    np         = 2'd0;
                                    octal_next = {5'd0, item_byte[2:0]};
                                    cand_phase = PH_OCT;
                                end
                                else
                                begin
                                    pre0 = item_byte;
                                end
                            end
                        endcase
                    end
                end
                PH_HEX0:
                begin
                    if (is_hex(item_byte))
                    begin
                        hex_digit_next = item_byte;
                        cand_phase     = PH_HEX1;
                    end
                    else
                    begin
                        np        = 2'd1;
                        pre0      = x_char;
                        use_plain = 1'b1;
                    end
                end
                PH_HEX1:
                begin
                    cand_phase = PH_IDLE;
                    if (is_hex(item_byte))
                    begin
                        np   = 2'd1;
                        pre0 = {hex_val(hex_digit_reg), hex_val(item_byte)};
                    end
                    else
                    begin
                        np        = 2'd2;
                        pre0      = x_char;
                        pre1      = hex_digit_reg;
                        use_plain = 1'b1;
                    end
                end
                PH_OCT:
                begin
                    if (is_oct(item_byte))
                    begin
                        octal_next = {octal_reg[4:0], item_byte[2:0]};
                    end
                    else
                    begin
                        np        = 2'd1;
                        pre0      = octal_reg;
                        use_plain = 1'b1;
                    end
                end
                PH_DONE:
                begin
                    cand_phase = PH_DONE;
                end
                default:
                begin
                    cand_phase = phase_reg;
                end
            endcase
            if (use_plain)
            begin
                cand_phase = plain_phase;
            end
        end
    end

    // Candidate byte list, then cut by the output limit.
    always_comb
    begin
        cand[0] = pre0;
        cand[1] = pre1;
        cand[2] = item_byte;
        if (use_plain && plain_emit)
        begin
            cand[np] = item_byte;
        end
        cand_n  = np + {1'b0, use_plain & plain_emit};
        lim     = (output_limit < MAX_OUTPUT_BYTES) ? output_limit : MAX_OUTPUT_BYTES;
        room    = (lim > count_reg) ? (lim - count_reg) : 16'd0;
        n_ok    = (room >= {14'd0, cand_n}) ? cand_n : room[1:0];
        reached = (room != 16'd0) && (room <= {14'd0, cand_n});
    end

    always_comb
    begin
        push.n = n_ok + {1'b0, item_end};
        for (int i = 0; i < 3; i++)
        begin
            ob = (zero_to_high && cand[i] == 8'h00) ? ZERO_SUBST : cand[i];
            if (2'(i) < n_ok)
            begin
                push.entries[i] = '{out_byte: ob, has_byte: 1'b1, is_last: 1'b0,
                                    total_length: 16'd0};
            end
            else
            begin
                push.entries[i] = '{out_byte: 8'h00, has_byte: 1'b0, is_last: 1'b1,
                                    total_length: count_reg + {14'd0, n_ok}};
            end
        end
        if (!item_valid)
        begin
            push.n = 2'd0;
        end
    end

    always_comb
    begin
        if (item_end)
        begin
            phase_next = PH_START;
            count_next = 16'd0;
        end
        else
        begin
            phase_next = reached ? PH_DONE : cand_phase;
            count_next = count_reg + {14'd0, n_ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            hex_digit_reg <= 8'h00;
            x_upper_reg   <= 1'b0;
            octal_reg     <= 8'h00;
            count_reg     <= 16'd0;
        end
        else if (item_valid)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            hex_digit_reg <= item_end ? 8'h00 : hex_digit_next;
            x_upper_reg   <= item_end ? 1'b0  : x_upper_next;
            octal_reg     <= item_end ? 8'h00 : octal_next;
        end
    end

endmodule
